// ===== hdl/rbc_pkg.sv =====
// Package for the relogin backoff controller: session state and event codes,
// reset values of the backoff table and the configuration register indexes.
// Depends on nothing.
`default_nettype none

package rbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE          = 3'd0,
    ST_TOKEN_INVALID = 3'd1,
    ST_PENDING       = 3'd2,
    ST_IN_PROGRESS   = 3'd3,
    ST_LOGIN_FAILED  = 3'd4,
    ST_NET_ERROR     = 3'd5,
    ST_TWO_FACTOR    = 3'd6,
    ST_CONNECTING    = 3'd7
  } session_t;

  typedef enum logic [2:0] {
    EV_SET_ENABLE   = 3'd0,
    EV_AUTH_FAILURE = 3'd1,
    EV_POLL         = 3'd2,
    EV_STARTED      = 3'd3,
    EV_SUCCESS      = 3'd4,
    EV_FAILURE      = 3'd5
  } event_t;

  localparam logic [1:0] REASON_TWO_FACTOR = 2'd0;
  localparam logic [1:0] REASON_INVALID    = 2'd1;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THIRD  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST   = 8'd3;

  localparam logic [31:0] RST_FIRST_MS  = 32'd60000;
  localparam logic [31:0] RST_SECOND_MS = 32'd300000;
  localparam logic [31:0] RST_THIRD_MS  = 32'd900000;
  localparam logic [31:0] RST_LAST_MS   = 32'd1800000;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  function automatic logic is_retryable(input session_t s);
    return (s == ST_PENDING) || (s == ST_LOGIN_FAILED) || (s == ST_NET_ERROR);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/relogin_backoff_controller_unit.sv =====
// Top level of the relogin backoff controller: event decode, session state,
// backoff delay selection and the due check. Uses rbc_pkg.
// The result of an input transfer is registered and shows on the master side in the next cycle.
// Throughput: one event per cycle; the state update and the 32-bit elapsed
// time compare sit between the state registers and the result register.
// A new event is taken whenever the result register is empty or being drained.
// Synchronous reset clears the session state, counters and output valid, and
// loads the backoff table with its default delays.
`default_nettype none

module relogin_backoff_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // now_ms [31:0], enable_value [32], failure_reason [34:33], zero [39:35]
  input  wire logic [39:0]                   s_tdata,
  // kind [2:0]
  input  wire logic [2:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // session_state [2:0], relogin_due [3], failure_count [11:4],
  // retry_delay_ms [43:12], zero [47:44]
  output logic [47:0]                        m_tdata
);
  import rbc_pkg::*;

  logic [31:0] backoff_first_ms;
  logic [31:0] backoff_second_ms;
  logic [31:0] backoff_third_ms;
  logic [31:0] backoff_last_ms;

  session_t    session_code, session_code_next;
  logic        auto_enabled, auto_enabled_next;
  logic        retry_scheduled, retry_scheduled_next;
  logic [7:0]  fail_count, fail_count_next;
  logic [31:0] anchor_time, anchor_time_next;
  logic [31:0] current_delay, current_delay_next;
  logic        due;

  logic        out_valid;
  logic [43:0] out_data;

  logic [31:0] now_ms;
  logic        enable_value;
  logic [1:0]  failure_reason;
  logic [7:0]  count_inc;
  logic [31:0] table_delay;
  logic        may_retry;
  logic        accept;

  assign now_ms         = s_tdata[31:0];
  assign enable_value   = s_tdata[32];
  assign failure_reason = s_tdata[34:33];

  assign cfg_ready = 1'b1;
  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {4'd0, out_data};

  assign may_retry = auto_enabled && retry_scheduled && is_retryable(session_code);
  assign count_inc = (fail_count < COUNT_MAX) ? fail_count + 8'd1 : fail_count;

  always_comb begin
    case (count_inc)
      8'd0:    table_delay = 32'd0;
      8'd1:    table_delay = backoff_first_ms;
      8'd2:    table_delay = backoff_second_ms;
      8'd3:    table_delay = backoff_third_ms;
      default: table_delay = backoff_last_ms;
    endcase
  end

  always_comb begin
    session_code_next    = session_code;
    auto_enabled_next    = auto_enabled;
    retry_scheduled_next = retry_scheduled;
    fail_count_next      = fail_count;
    anchor_time_next     = anchor_time;
    current_delay_next   = current_delay;
    unique case (event_t'(s_tuser))
      EV_SET_ENABLE: begin
        auto_enabled_next = enable_value;
        if (!enable_value) begin
          retry_scheduled_next = 1'b0;
          if (is_retryable(session_code)) session_code_next = ST_TOKEN_INVALID;
        end
      end
      EV_AUTH_FAILURE: begin
        fail_count_next    = 8'd0;
        anchor_time_next   = now_ms;
        current_delay_next = 32'd0;
        if (auto_enabled) begin
          session_code_next    = ST_PENDING;
          retry_scheduled_next = 1'b1;
        end else begin
          session_code_next    = ST_TOKEN_INVALID;
          retry_scheduled_next = 1'b0;
        end
      end
      EV_STARTED: begin
        if (may_retry) begin
          retry_scheduled_next = 1'b0;
          session_code_next    = ST_IN_PROGRESS;
        end
      end
      EV_SUCCESS: begin
        session_code_next    = ST_CONNECTING;
        retry_scheduled_next = 1'b0;
        fail_count_next      = 8'd0;
        anchor_time_next     = 32'd0;
        current_delay_next   = 32'd0;
      end
      EV_FAILURE: begin
        if (failure_reason == REASON_TWO_FACTOR) begin
          session_code_next    = ST_TWO_FACTOR;
          retry_scheduled_next = 1'b0;
          current_delay_next   = 32'd0;
        end else begin
          fail_count_next      = count_inc;
          anchor_time_next     = now_ms;
          current_delay_next   = table_delay;
          retry_scheduled_next = auto_enabled;
          session_code_next    = (failure_reason == REASON_INVALID) ?
                                 ST_LOGIN_FAILED : ST_NET_ERROR;
        end
      end
      default: begin
      end
    endcase
    due = auto_enabled_next && retry_scheduled_next &&
          is_retryable(session_code_next) &&
          ((now_ms - anchor_time_next) >= current_delay_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_first_ms  <= RST_FIRST_MS;
      backoff_second_ms <= RST_SECOND_MS;
      backoff_third_ms  <= RST_THIRD_MS;
      backoff_last_ms   <= RST_LAST_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST:  backoff_first_ms  <= cfg_data;
        REG_SECOND: backoff_second_ms <= cfg_data;
        REG_THIRD:  backoff_third_ms  <= cfg_data;
        REG_LAST:   backoff_last_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_code    <= ST_IDLE;
      auto_enabled    <= 1'b0;
      retry_scheduled <= 1'b0;
      fail_count      <= 8'd0;
      anchor_time     <= 32'd0;
      current_delay   <= 32'd0;
    end else if (accept) begin
      session_code    <= session_code_next;
      auto_enabled    <= auto_enabled_next;
      retry_scheduled <= retry_scheduled_next;
      fail_count      <= fail_count_next;
      anchor_time     <= anchor_time_next;
      current_delay   <= current_delay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {current_delay_next, fail_count_next, due, session_code_next};
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for relogin_backoff_controller_unit: drives session events and
// backoff table writes, predicts every status transfer and compares it field by field.
// Depends on rbc_pkg and the controller RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbc_pkg::*;

  localparam logic [1:0] REASON_NETWORK = 2'd2;
  localparam logic [1:0] REASON_SPARE   = 2'd3;
  localparam logic [2:0] EV_SPARE_A     = 3'd6;
  localparam logic [2:0] EV_SPARE_B     = 3'd7;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned RANDOM_ITEMS    = 900;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] delay_ms;
    logic [7:0]  count;
    logic        due;
    session_t    state;
  } status_t;

  class relogin_tracker;
    logic [31:0] backoff_ms [4];
    session_t    code;
    bit          enabled;
    bit          scheduled;
    logic [7:0]  count;
    logic [31:0] anchor;
    logic [31:0] delay_ms;
    status_t     awaited [$];
    int unsigned failures;

    function new();
      backoff_ms[0] = RST_FIRST_MS;
      backoff_ms[1] = RST_SECOND_MS;
      backoff_ms[2] = RST_THIRD_MS;
      backoff_ms[3] = RST_LAST_MS;
      code = ST_IDLE;
      enabled = 1'b0;
      scheduled = 1'b0;
      count = '0;
      anchor = '0;
      delay_ms = '0;
      failures = 0;
    endfunction

    function void store_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
      case (index)
        REG_FIRST:  backoff_ms[0] = value;
        REG_SECOND: backoff_ms[1] = value;
        REG_THIRD:  backoff_ms[2] = value;
        REG_LAST:   backoff_ms[3] = value;
        default: ;
      endcase
    endfunction

    function bit can_retry_from(session_t s);
      return (s == ST_PENDING) || (s == ST_LOGIN_FAILED) || (s == ST_NET_ERROR);
    endfunction

    function bit retry_allowed();
      return enabled && scheduled && can_retry_from(code);
    endfunction

    function logic [31:0] delay_for_count(logic [7:0] n);
      if (n == 8'd0) return 32'd0;
      if (n >= 8'd4) return backoff_ms[3];
      return backoff_ms[n - 8'd1];
    endfunction

    function void note_event(logic [2:0] kind, logic [31:0] now_ms, logic en,
                             logic [1:0] reason);
      status_t     s;
      logic [31:0] elapsed;
      case (kind)
        EV_SET_ENABLE: begin
          enabled = en;
          if (!en) begin
            scheduled = 1'b0;
            if (can_retry_from(code)) code = ST_TOKEN_INVALID;
          end
        end
        EV_AUTH_FAILURE: begin
          count = '0;
          anchor = now_ms;
          delay_ms = '0;
          scheduled = enabled;
          code = enabled ? ST_PENDING : ST_TOKEN_INVALID;
        end
        EV_STARTED: begin
          if (retry_allowed()) begin
            scheduled = 1'b0;
            code = ST_IN_PROGRESS;
          end
        end
        EV_SUCCESS: begin
          code = ST_CONNECTING;
          scheduled = 1'b0;
          count = '0;
          anchor = '0;
          delay_ms = '0;
        end
        EV_FAILURE: begin
          if (reason == REASON_TWO_FACTOR) begin
            code = ST_TWO_FACTOR;
            scheduled = 1'b0;
            delay_ms = '0;
          end else begin
            if (count != COUNT_MAX) count = count + 8'd1;
            anchor = now_ms;
            delay_ms = delay_for_count(count);
            scheduled = enabled;
            code = (reason == REASON_INVALID) ? ST_LOGIN_FAILED : ST_NET_ERROR;
          end
        end
        default: ;
      endcase
      elapsed = now_ms - anchor;
      s.pad = '0;
      s.delay_ms = delay_ms;
      s.count = count;
      s.due = retry_allowed() && (elapsed >= delay_ms);
      s.state = code;
      awaited.push_back(s);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("status transfer with none outstanding: state %0d due %0b count %0d delay %0d",
                   got.state, got.due, got.count, got.delay_ms);
        return;
      end
      want = awaited.pop_front();
      if (got.state !== want.state || got.due !== want.due || got.count !== want.count ||
          got.delay_ms !== want.delay_ms) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"status mismatch: expected state %0d due %0b count %0d delay %0d, ",
                    "got state %0d due %0b count %0d delay %0d"},
                   want.state, want.due, want.count, want.delay_ms,
                   got.state, got.due, got.count, got.delay_ms);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [39:0]            s_tdata = '0;
  logic [2:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [47:0]            m_tdata;

  relogin_tracker tracker = new();
  bit             hold_off_req = 1'b0;
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    events_sent = 0;
  logic [31:0]    clock_ms = '0;

  relogin_backoff_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_status(status_t'(m_tdata));
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_off_req) begin
          m_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((tick % 3) != 2);
          endcase
        end
      end
    end
  end

  task automatic send_event(logic [2:0] kind, logic [31:0] now_ms, logic en,
                            logic [1:0] reason);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'b0, reason, en, now_ms};
    do @(posedge clk); while (!s_tready);
    tracker.note_event(kind, now_ms, en, reason);
    clock_ms = now_ms;
    events_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.store_reg(index, value);
  endtask

  task automatic load_table(logic [31:0] first, logic [31:0] second, logic [31:0] third,
                            logic [31:0] last);
    drain();
    program_reg(REG_FIRST, first);
    program_reg(REG_SECOND, second);
    program_reg(REG_THIRD, third);
    program_reg(REG_LAST, last);
    program_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Times cluster around the point where the backoff delay runs out.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1, 2, 3: return tracker.anchor + tracker.delay_ms - 32'd1 + 32'($urandom_range(0, 2));
      4: return tracker.anchor + 32'($urandom_range(0, 3));
      5: return tracker.anchor - 32'($urandom_range(1, 3));
      default: return clock_ms + 32'($urandom_range(0, 400000));
    endcase
  endfunction

  task automatic relogin_session();
    int unsigned rounds;
    if ($urandom_range(0, 4) != 0) send_event(EV_SET_ENABLE, pick_time(), 1'b1, 2'($urandom));
    send_event(EV_AUTH_FAILURE, pick_time(), 1'($urandom), 2'($urandom));
    rounds = $urandom_range(1, 6);
    repeat (rounds) begin
      repeat ($urandom_range(0, 3))
        send_event(EV_POLL, pick_time(), 1'($urandom), 2'($urandom));
      send_event(EV_STARTED, pick_time(), 1'($urandom), 2'($urandom));
      case ($urandom_range(0, 9))
        0: send_event(EV_FAILURE, pick_time(), 1'($urandom), REASON_TWO_FACTOR);
        1: send_event(EV_SET_ENABLE, pick_time(), 1'b0, 2'($urandom));
        2: send_event(EV_AUTH_FAILURE, pick_time(), 1'($urandom), 2'($urandom));
        default: send_event(EV_FAILURE, pick_time(), 1'($urandom), 2'($urandom_range(1, 3)));
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      send_event(EV_SUCCESS, pick_time(), 1'($urandom), 2'($urandom));
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_event(EV_POLL, 32'd0, 1'b0, REASON_TWO_FACTOR);
    send_event(EV_STARTED, 32'd5, 1'b1, REASON_SPARE);
    send_event(EV_SET_ENABLE, 32'd10, 1'b1, REASON_TWO_FACTOR);
    send_event(EV_AUTH_FAILURE, 32'd1000, 1'b0, REASON_TWO_FACTOR);
    send_event(EV_STARTED, 32'd1000, 1'b0, REASON_INVALID);
    send_event(EV_FAILURE, 32'd2000, 1'b0, REASON_INVALID);
    send_event(EV_POLL, 32'd61999, 1'b1, REASON_NETWORK);
    send_event(EV_POLL, 32'd62000, 1'b0, REASON_TWO_FACTOR);
    send_event(EV_STARTED, 32'd62000, 1'b1, REASON_SPARE);
    send_event(EV_FAILURE, 32'd70000, 1'b0, REASON_NETWORK);
    send_event(EV_FAILURE, 32'hFFFF_FFFF, 1'b1, REASON_SPARE);
    send_event(EV_FAILURE, 32'd0, 1'b0, REASON_NETWORK);
    send_event(EV_FAILURE, 32'd100, 1'b1, REASON_INVALID);
    send_event(EV_SPARE_A, 32'd1800099, 1'b0, REASON_INVALID);
    send_event(EV_SPARE_B, 32'd1800100, 1'b1, REASON_SPARE);
    send_event(EV_SET_ENABLE, 32'd1800200, 1'b0, REASON_SPARE);
    send_event(EV_SET_ENABLE, 32'd1800300, 1'b1, REASON_INVALID);
    send_event(EV_FAILURE, 32'd1800400, 1'b1, REASON_TWO_FACTOR);
    send_event(EV_STARTED, 32'd1800500, 1'b1, REASON_NETWORK);
    send_event(EV_SET_ENABLE, 32'd1800600, 1'b0, REASON_TWO_FACTOR);
    send_event(EV_AUTH_FAILURE, 32'hFFFF_FFFF, 1'b1, REASON_SPARE);
    send_event(EV_FAILURE, 32'h8000_0000, 1'b0, REASON_INVALID);
    send_event(EV_SUCCESS, 32'hFFFF_FFFF, 1'b1, REASON_SPARE);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        1: load_table(32'd0, 32'd0, 32'd0, 32'd0);
        2: load_table(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: load_table(32'd1, 32'd2, 32'd3, 32'd5);
        4: load_table($urandom, $urandom, $urandom, $urandom);
        5: load_table(32'hFFFF_FFFF, 32'd1000, 32'd3, 32'd0);
        default: ;
      endcase
      if (p == 3) hold_off_req = 1'b1;
      phase_start = events_sent;
      while (events_sent < phase_start + RANDOM_ITEMS / PHASE_COUNT) begin
        if ($urandom_range(0, 4) == 0)
          send_event(3'($urandom), ($urandom_range(0, 1) == 0) ? $urandom : pick_time(),
                     1'($urandom), 2'($urandom));
        else
          relogin_session();
      end
      if (p == 2) begin
        // A long run of failures drives the count into saturation.
        send_event(EV_SET_ENABLE, pick_time(), 1'b1, 2'($urandom));
        send_event(EV_AUTH_FAILURE, pick_time(), 1'($urandom), 2'($urandom));
        repeat (262) begin
          if ($urandom_range(0, 7) == 0)
            send_event(EV_POLL, pick_time(), 1'($urandom), 2'($urandom));
          send_event(EV_FAILURE, pick_time(), 1'($urandom), 2'($urandom_range(1, 3)));
        end
      end
    end

    drain();
    if (tracker.failures == 0 && tracker.awaited.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
